>>> hw/rtl/rbf_pkg.sv
// Shared types and constants for the ring buffer FIFO with bulk requests.
// Used by every module of the block and by its port checker.
package rbf_pkg;

  localparam int DEPTH      = 256;
  localparam int WORD_WIDTH = 32;
  localparam int MAX_BURST  = 64;
  localparam int AW         = $clog2(DEPTH);
  localparam int CNT_W      = 7;
  localparam int OFS_W      = 8;
  localparam int IDX_W      = $clog2(MAX_BURST);
  localparam int Q_DEPTH    = 4;
  localparam int QPW        = $clog2(Q_DEPTH);

  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_GET   = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_POP   = 3'd3;
  localparam logic [2:0] OP_FLUSH = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;

  typedef struct packed {
    logic [2:0]            op;
    logic [CNT_W-1:0]      count;
    logic [OFS_W-1:0]      offset;
    logic [WORD_WIDTH-1:0] data;
  } req_t;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] data_out;
    logic [1:0]            status;
    logic                  last;
    logic [7:0]            fill_level;
    logic [7:0]            free_slots;
  } rsp_t;

  // one queued command: optional store write, optional read run, optional status word
  typedef struct packed {
    logic                  wr;
    logic [WORD_WIDTH-1:0] data;
    logic [AW-1:0]         wr_addr;
    logic                  rd;
    logic [AW-1:0]         rd_addr;
    logic [CNT_W-1:0]      rd_count;
    logic                  stat_emit;
    logic [1:0]            status;
    logic [7:0]            fill;
    logic [7:0]            free;
  } cmd_t;

endpackage

>>> hw/rtl/ring_buffer_fifo_bulk.sv
// Ring buffer FIFO with bulk put, get, peek, pop and flush; holds up to DEPTH-1 words.
// Built from rbf_front, rbf_queue and rbf_back; types from rbf_pkg.
//
// One request word is taken per cycle while the four-entry command queue has room;
// a put burst stores one word per cycle. Get and peek of n words give n results,
// one per cycle unless the output stalls, from the store's single read port, so a
// queued read run holds the queue head until its last word is read. Each other known
// op gives one result at the queue head. Results leave through an output register.
// The store has no reset and needs no clearing pass: only written words can be read.
module ring_buffer_fifo_bulk (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rbf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rbf_pkg::rsp_t rsp
);
  import rbf_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_nonempty;
  logic pop;
  cmd_t head;

  rbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  rbf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head     (head)
  );

  rbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .head       (head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

>>> hw/rtl/rbf_queue.sv
// Short command queue between the front and back parts of the ring buffer FIFO.
// Depends on rbf_pkg for the command type and depth.
module rbf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rbf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output rbf_pkg::cmd_t head
);
  import rbf_pkg::*;

  cmd_t           slots [Q_DEPTH];
  logic [QPW-1:0] wptr;
  logic [QPW-1:0] rptr;
  logic [QPW:0]   cnt;

  assign full     = (cnt == (QPW+1)'(Q_DEPTH));
  assign nonempty = (cnt != '0);
  assign head     = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + QPW'(1);
      if (pop)  rptr <= rptr + QPW'(1);
      unique case ({push, pop})
        2'b10:   cnt <= cnt + (QPW+1)'(1);
        2'b01:   cnt <= cnt - (QPW+1)'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> hw/rtl/rbf_front.sv
// Front part of the ring buffer FIFO: accepts request words, checks space and
// fill, moves the indices and queues commands for the back part. Uses rbf_pkg.
module rbf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rbf_pkg::req_t req,
  output logic          push,
  output rbf_pkg::cmd_t push_cmd,
  input  logic          q_full
);
  import rbf_pkg::*;

  logic [AW-1:0]    ri, ri_next;
  logic [AW-1:0]    wi, wi_next;
  logic [CNT_W-1:0] brem, brem_next;
  logic             bacc, bacc_next;

  logic             accept;
  logic [AW-1:0]    fill;
  logic [AW-1:0]    free;
  logic [AW-1:0]    fill_after;
  logic             put_go;
  logic [CNT_W-1:0] rem_cur;
  logic             acc_cur;
  cmd_t             cmd;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign fill      = wi - ri;
  assign free      = AW'(DEPTH - 1) - fill;

  always_comb begin
    ri_next   = ri;
    wi_next   = wi;
    brem_next = brem;
    bacc_next = bacc;
    put_go    = 1'b0;
    rem_cur   = brem;
    acc_cur   = bacc;
    cmd       = '0;
    cmd.data  = req.data;

    if (brem != '0) begin
      put_go = 1'b1;
    end else begin
      unique case (req.op)
        OP_PUT: begin
          if (req.count == '0) begin
            cmd.stat_emit = 1'b1;
            cmd.status    = ST_ZERO;
          end else begin
            put_go  = 1'b1;
            rem_cur = req.count;
            acc_cur = (req.count <= CNT_W'(MAX_BURST)) && (AW'(req.count) <= free);
          end
        end
        OP_GET, OP_PEEK: begin
          if (req.count == '0) begin
            cmd.stat_emit = 1'b1;
            cmd.status    = ST_ZERO;
          end else if (req.op == OP_GET) begin
            if (req.count > CNT_W'(MAX_BURST) || AW'(req.count) > fill) begin
              cmd.stat_emit = 1'b1;
              cmd.status    = ST_REFUSED;
            end else begin
              cmd.rd       = 1'b1;
              cmd.rd_addr  = ri;
              cmd.rd_count = req.count;
              ri_next      = ri + AW'(req.count);
            end
          end else begin
            if (req.count > CNT_W'(MAX_BURST) ||
                ({1'b0, req.offset} + (OFS_W+1)'(req.count)) > (OFS_W+1)'(fill)) begin
              cmd.stat_emit = 1'b1;
              cmd.status    = ST_REFUSED;
            end else begin
              cmd.rd       = 1'b1;
              cmd.rd_addr  = ri + AW'(req.offset);
              cmd.rd_count = req.count;
            end
          end
        end
        OP_POP: begin
          cmd.stat_emit = 1'b1;
          if (req.count == '0) begin
            cmd.status = ST_ZERO;
          end else if (AW'(req.count) > fill) begin
            cmd.status = ST_REFUSED;
          end else begin
            cmd.status = ST_OK;
            ri_next    = ri + AW'(req.count);
          end
        end
        OP_FLUSH: begin
          cmd.stat_emit = 1'b1;
          cmd.status    = ST_OK;
          ri_next       = wi;
        end
        default: ;
      endcase
    end

    if (put_go) begin
      cmd.wr      = acc_cur;
      cmd.wr_addr = wi;
      if (acc_cur) wi_next = wi + AW'(1);
      brem_next = rem_cur - CNT_W'(1);
      bacc_next = acc_cur;
      if (rem_cur == CNT_W'(1)) begin
        cmd.stat_emit = 1'b1;
        cmd.status    = acc_cur ? ST_OK : ST_REFUSED;
        bacc_next     = 1'b0;
      end
    end

    fill_after = wi_next - ri_next;
    cmd.fill   = 8'(fill_after);
    cmd.free   = 8'(AW'(DEPTH - 1) - fill_after);
  end

  assign push     = accept && (cmd.wr || cmd.rd || cmd.stat_emit);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ri   <= '0;
      wi   <= '0;
      brem <= '0;
      bacc <= 1'b0;
    end else if (accept) begin
      ri   <= ri_next;
      wi   <= wi_next;
      brem <= brem_next;
      bacc <= bacc_next;
    end
  end

endmodule

>>> hw/rtl/rbf_back.sv
// Back part of the ring buffer FIFO: owns the word store, performs queued writes
// and read runs, and drives the registered result channel. Uses rbf_pkg.
module rbf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_nonempty,
  input  rbf_pkg::cmd_t head,
  output logic          pop,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rbf_pkg::rsp_t rsp
);
  import rbf_pkg::*;

  logic [WORD_WIDTH-1:0] store [DEPTH];
  logic [IDX_W-1:0]      idx;
  logic                  load;
  logic                  emit_rd;
  logic                  emit_st;
  logic                  last_word;
  logic [AW-1:0]         rd_addr;
  rsp_t                  rsp_r;
  logic                  valid_r;

  assign load      = !valid_r || !rsp_stall;
  assign emit_rd   = q_nonempty && head.rd && load;
  assign emit_st   = q_nonempty && head.stat_emit && load;
  assign last_word = ((CNT_W'(idx) + CNT_W'(1)) == head.rd_count);
  assign rd_addr   = head.rd_addr + AW'(idx);
  assign pop       = q_nonempty && ((!head.rd && !head.stat_emit) || emit_st ||
                                    (emit_rd && last_word));

  // store write, and registered read straight into the result word
  always_ff @(posedge clk) begin
    if (pop && head.wr) begin
      store[head.wr_addr] <= head.data;
    end
    if (emit_rd) begin
      rsp_r.data_out <= store[rd_addr];
    end else if (emit_st) begin
      rsp_r.data_out <= '0;
    end
    if (emit_rd || emit_st) begin
      rsp_r.status     <= emit_rd ? ST_OK : head.status;
      rsp_r.last       <= emit_rd ? last_word : 1'b1;
      rsp_r.fill_level <= head.fill;
      rsp_r.free_slots <= head.free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
      idx     <= '0;
    end else begin
      if (load) valid_r <= emit_rd || emit_st;
      if (emit_rd) idx <= last_word ? '0 : idx + IDX_W'(1);
    end
  end

  assign rsp_valid = valid_r;
  assign rsp       = rsp_r;

endmodule

>>> hw/rtl/rbf_checker.sv
// Port checker for the ring buffer FIFO, bound to the top level.
// Uses rbf_pkg for the payload types and status codes.
module rbf_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input rbf_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input rbf_pkg::rsp_t rsp
);
  import rbf_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  a_fill_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.fill_level + rsp.free_slots) == 8'(DEPTH - 1))
    else $error("fill level and free slots disagree");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last)
    else $error("refusal not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.data_out == '0)
    else $error("refusal carries data");

endmodule

bind ring_buffer_fifo_bulk rbf_checker u_rbf_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for ring_buffer_fifo_bulk: directed and random put, get, peek, pop
// and flush requests, with every result word checked against a word-level FIFO prediction.
// Depends on rbf_pkg and the ring_buffer_fifo_bulk RTL.
module testbench;
  import rbf_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int TAIL_CYCLES  = 20;
  localparam int CNT_MAX      = (1 << CNT_W) - 1;
  localparam int OFS_MAX      = (1 << OFS_W) - 1;
  localparam int OP_CODES     = 8;

  typedef struct {
    req_t word;
    bit   hold;
  } pending_word_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  pending_word_t         pending_req[$];
  rsp_t                  expected_rsp[$];
  logic [WORD_WIDTH-1:0] fifo_mem [DEPTH];
  int                    head_idx   = 0;
  int                    tail_idx   = 0;
  int                    burst_left = 0;
  bit                    burst_ok   = 1'b0;
  int                    gen_fill   = 0;
  int                    n_items    = 0;
  int                    errors     = 0;
  int                    cycles     = 0;
  int                    run_left   = 0;
  int                    gap_left   = 0;
  int                    stall_left = 0;
  stall_mode_e           stall_mode = STALL_NONE;
  bit                    req_fired  = 1'b0;

  ring_buffer_fifo_bulk dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int words_held();
    return (tail_idx - head_idx + DEPTH) % DEPTH;
  endfunction

  function automatic void expect_word(logic [WORD_WIDTH-1:0] data, logic [1:0] status, bit last);
    rsp_t r;
    int   fill;
    int   free_n;
    fill         = words_held();
    free_n       = DEPTH - 1 - fill;
    r.data_out   = data;
    r.status     = status;
    r.last       = last;
    r.fill_level = fill[7:0];
    r.free_slots = free_n[7:0];
    expected_rsp.push_back(r);
  endfunction

  function automatic void take_burst_word(logic [WORD_WIDTH-1:0] data);
    if (burst_ok) begin
      fifo_mem[tail_idx] = data;
      tail_idx = (tail_idx + 1) % DEPTH;
    end
    burst_left--;
    if (burst_left == 0) begin
      expect_word('0, burst_ok ? ST_OK : ST_REFUSED, 1'b1);
      burst_ok = 1'b0;
    end
  endfunction

  function automatic void predict_fifo_results(req_t w);
    int fill;
    int cnt;
    int ofs;
    int reach;
    int start;
    int i;
    fill = words_held();
    cnt  = int'(w.count);
    ofs  = int'(w.offset);
    if (burst_left != 0) begin
      take_burst_word(w.data);
    end else begin
      case (w.op)
        OP_PUT: begin
          if (cnt == 0) begin
            expect_word('0, ST_ZERO, 1'b1);
          end else begin
            burst_ok   = cnt <= MAX_BURST && cnt <= DEPTH - 1 - fill;
            burst_left = cnt;
            take_burst_word(w.data);
          end
        end
        OP_GET, OP_PEEK: begin
          reach = (w.op == OP_GET) ? cnt : ofs + cnt;
          if (cnt == 0) begin
            expect_word('0, ST_ZERO, 1'b1);
          end else if (cnt > MAX_BURST || reach > fill) begin
            expect_word('0, ST_REFUSED, 1'b1);
          end else begin
            start = (w.op == OP_GET) ? head_idx : (head_idx + ofs) % DEPTH;
            if (w.op == OP_GET) head_idx = (head_idx + cnt) % DEPTH;
            for (i = 0; i < cnt; i++) begin
              expect_word(fifo_mem[(start + i) % DEPTH], ST_OK, i == cnt - 1);
            end
          end
        end
        OP_POP: begin
          if (cnt == 0) begin
            expect_word('0, ST_ZERO, 1'b1);
          end else if (cnt > fill) begin
            expect_word('0, ST_REFUSED, 1'b1);
          end else begin
            head_idx = (head_idx + cnt) % DEPTH;
            expect_word('0, ST_OK, 1'b1);
          end
        end
        OP_FLUSH: begin
          head_idx = tail_idx;
          expect_word('0, ST_OK, 1'b1);
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void check_field(string name, logic [WORD_WIDTH-1:0] want,
                                      logic [WORD_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic int min2(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [WORD_WIDTH-1:0] rand_data();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_word(logic [2:0] op, int cnt, int ofs,
                                   logic [WORD_WIDTH-1:0] data, bit hold);
    pending_word_t item;
    item.word.op     = op;
    item.word.count  = cnt[CNT_W-1:0];
    item.word.offset = ofs[OFS_W-1:0];
    item.word.data   = data;
    item.hold        = hold;
    pending_req.push_back(item);
    n_items++;
  endfunction

  // burst words after the first carry random op, count and offset
  function automatic void add_request(logic [2:0] op, int cnt, int ofs, bit hold);
    int i;
    add_word(op, cnt, ofs, rand_data(), hold);
    case (op)
      OP_PUT: begin
        for (i = 1; i < cnt; i++) begin
          add_word(3'($urandom_range(0, OP_CODES - 1)), $urandom_range(0, CNT_MAX),
                   $urandom_range(0, OFS_MAX), rand_data(), 1'b0);
        end
        if (cnt > 0 && cnt <= MAX_BURST && cnt <= DEPTH - 1 - gen_fill) gen_fill += cnt;
      end
      OP_GET:   if (cnt > 0 && cnt <= MAX_BURST && cnt <= gen_fill) gen_fill -= cnt;
      OP_POP:   if (cnt > 0 && cnt <= gen_fill) gen_fill -= cnt;
      OP_FLUSH: gen_fill = 0;
      default: ;
    endcase
  endfunction

  function automatic void add_random_request();
    int pick;
    int r;
    int cnt;
    int ofs;
    int fill;
    int room;
    bit hold;
    fill = gen_fill;
    room = DEPTH - 1 - fill;
    hold = ($urandom_range(0, 39) == 0);
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 19);
    ofs  = $urandom_range(0, OFS_MAX);
    if (pick < 40) begin
      if (r == 0) cnt = 0;
      else if (r == 1) cnt = (room < MAX_BURST) ? room + 1 :
                             $urandom_range(MAX_BURST + 1, MAX_BURST + 8);
      else if (room == 0) cnt = 1;
      else cnt = $urandom_range(1, min2(room, (r < 5) ? MAX_BURST : 8));
      add_request(OP_PUT, cnt, ofs, hold);
    end else if (pick < 60) begin
      if (r == 0) cnt = 0;
      else if (r == 1) cnt = (fill < MAX_BURST) ? fill + 1 : $urandom_range(MAX_BURST + 1, CNT_MAX);
      else if (fill == 0) cnt = 1;
      else cnt = $urandom_range(1, min2(fill, (r < 4) ? MAX_BURST : 8));
      add_request(OP_GET, cnt, ofs, hold);
    end else if (pick < 76) begin
      if (r == 0) begin
        cnt = 0;
      end else if (r == 1 || fill == 0) begin
        cnt = $urandom_range(1, CNT_MAX);
      end else begin
        ofs = $urandom_range(0, fill - 1);
        cnt = $urandom_range(1, min2(fill - ofs, (r < 4) ? MAX_BURST : 8));
      end
      add_request(OP_PEEK, cnt, ofs, hold);
    end else if (pick < 88) begin
      if (r == 0) cnt = 0;
      else if (r == 1) cnt = min2(fill + 1, CNT_MAX);
      else if (fill == 0) cnt = 1;
      else cnt = $urandom_range(1, min2(fill, 16));
      add_request(OP_POP, cnt, ofs, hold);
    end else if (pick < 94) begin
      add_request(OP_FLUSH, $urandom_range(0, CNT_MAX), ofs, hold);
    end else begin
      add_request(3'($urandom_range(int'(OP_FLUSH) + 1, OP_CODES - 1)),
                  $urandom_range(0, CNT_MAX), ofs, hold);
    end
  endfunction

  initial begin
    int  i;
    bit  full_done;
    bit  first;
    full_done = 1'b0;

    add_request(OP_PUT, 0, 0, 1'b0);
    add_request(OP_GET, 0, 0, 1'b0);
    add_request(OP_PEEK, 0, 17, 1'b0);
    add_request(OP_POP, 0, 0, 1'b0);
    add_request(OP_GET, 1, 0, 1'b0);
    add_request(OP_PEEK, 1, 0, 1'b0);
    add_request(OP_POP, 1, 0, 1'b0);
    add_request(OP_FLUSH, CNT_MAX, OFS_MAX, 1'b0);
    for (i = int'(OP_FLUSH) + 1; i < OP_CODES; i++) add_request(i[2:0], 3, 2, 1'b0);
    add_word(OP_PUT, 1, 0, '1, 1'b0);
    add_word(OP_PUT, 3, OFS_MAX, '0, 1'b0);
    add_word(OP_GET, CNT_MAX, 0, 32'hA5A5_A5A5, 1'b0);
    add_word(OP_PEEK, MAX_BURST, 128, 32'h5A5A_5A5A, 1'b0);
    gen_fill = 4;
    add_request(OP_PEEK, 3, 1, 1'b0);
    add_request(OP_PEEK, 1, OFS_MAX, 1'b0);
    add_request(OP_PEEK, MAX_BURST + 1, 0, 1'b0);
    add_request(OP_GET, CNT_MAX, 0, 1'b0);
    add_request(OP_POP, 5, 0, 1'b0);
    add_request(OP_POP, 1, 0, 1'b0);
    add_request(OP_GET, 3, 0, 1'b0);

    add_request(OP_PUT, MAX_BURST + 1, 0, 1'b1);
    while (n_items < 260 || !full_done) begin
      if (!full_done && n_items >= 120) begin
        first = 1'b1;
        while (gen_fill < DEPTH - 1) begin
          add_request(OP_PUT, min2(MAX_BURST, DEPTH - 1 - gen_fill), $urandom_range(0, OFS_MAX),
                      first);
          first = 1'b0;
        end
        add_request(OP_PUT, 1, 0, 1'b0);
        add_request(OP_GET, MAX_BURST + 1, 0, 1'b0);
        add_request(OP_PEEK, MAX_BURST + 1, 0, 1'b0);
        add_request(OP_PEEK, MAX_BURST, DEPTH - 1 - MAX_BURST, 1'b0);
        add_request(OP_GET, MAX_BURST, 0, 1'b0);
        add_request(OP_POP, CNT_MAX, 0, 1'b0);
        full_done = 1'b1;
      end else begin
        add_random_request();
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_req.size() != 0 || expected_rsp.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // hold the word while stalled; a held-back word waits for all results
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_fired)) begin
      if (gap_left != 0 || pending_req.size() == 0 ||
          (pending_req[0].hold && expected_rsp.size() != 0)) begin
        req_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        req_valid <= 1'b1;
        req       <= pending_req[0].word;
        if (run_left > 1) begin
          run_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          run_left = $urandom_range(40, 120);
          gap_left = 0;
        end else begin
          run_left = $urandom_range(1, 12);
          gap_left = $urandom_range(1, 6);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 80);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  rsp_stall <= 1'b0;
      STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
      default:     rsp_stall <= (stall_left % 6 < 3);
    endcase
  end

  always @(posedge clk) begin
    rsp_t want;
    req_fired <= !rst && req_valid && !req_stall;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("unexpected result word: data_out %0h status %0d", rsp.data_out, rsp.status);
          errors++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("data_out", want.data_out, rsp.data_out);
          check_field("status", want.status, rsp.status);
          check_field("last", want.last, rsp.last);
          check_field("fill_level", want.fill_level, rsp.fill_level);
          check_field("free_slots", want.free_slots, rsp.free_slots);
        end
      end
      if (req_valid && !req_stall) begin
        predict_fifo_results(req);
        void'(pending_req.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
